### rtl/sac_pkg.sv
// shared types and constants for the symbol adjacency counter
// no dependencies
package sac_pkg;

  localparam int unsigned MaxSlots     = 128;
  localparam int unsigned MaxNeighbors = 32;
  localparam int unsigned CountBits    = 16;

  localparam int unsigned SymW   = 8;
  localparam int unsigned DirW   = 2;
  localparam int unsigned StW    = 3;
  localparam int unsigned SlotOW = 7;
  localparam int unsigned PosOW  = 5;
  localparam int unsigned CntOW  = 16;
  localparam int unsigned CharW  = 7;

  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLo = 8'h20;
  localparam logic [7:0] ChHi = 8'h7e;

  typedef enum logic [2:0] {
    StIncr        = 3'd0,
    StNewNeighbor = 3'd1,
    StNewSymbol   = 3'd2,
    StFiltered    = 3'd3,
    StFull        = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_idx;
    logic inc_idx;
    logic slot_rd;
    logic slot_wr;
    logic len_rd;
    logic list_wr;
    logic len_wr;
    logic take_slot;
    logic cnt_rd;
    logic out_load;
    status_e out_status;
    logic out_zero;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clearing;
    logic pass;
    logic slot_done;
    logic slot_hit;
    logic slots_full;
    logic list_done;
    logic list_hit;
    logic list_full;
  } sts_t;

endpackage

### rtl/symbol_adjacency_counter_top.sv
// symbol adjacency counter, top level
// one beat at a time: a new beat is stalled while the controller is busy or the held result is stalled
// the linear slot and neighbor list searches over single-port rams set the rate
// reset clears slot count and controller, then a clearing pass zeros the four list lengths of every slot
// depends on sac_pkg, sac_ctrl, sac_datapath
module symbol_adjacency_counter_top #(
  parameter int unsigned MaxSlots     = sac_pkg::MaxSlots,
  parameter int unsigned MaxNeighbors = sac_pkg::MaxNeighbors,
  parameter int unsigned CountBits    = sac_pkg::CountBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sac_pkg::SymW-1:0]   symbol_i,
  input  logic [sac_pkg::SymW-1:0]   neighbor_i,
  input  logic [sac_pkg::DirW-1:0]   direction_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sac_pkg::StW-1:0]    status_o,
  output logic [sac_pkg::SlotOW-1:0] symbol_slot_o,
  output logic [sac_pkg::PosOW-1:0]  neighbor_slot_o,
  output logic [sac_pkg::CntOW-1:0]  pair_count_o
);

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  sac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  sac_datapath #(
    .MaxSlots(MaxSlots), .MaxNeighbors(MaxNeighbors), .CountBits(CountBits)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .symbol_i, .neighbor_i, .direction_i,
    .status_o, .symbol_slot_o, .neighbor_slot_o, .pair_count_o
  );

endmodule

### rtl/sac_ram.sv
// generic single-port ram with registered read
// no dependencies
module sac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### rtl/sac_datapath.sv
// slot table, neighbor lists, counters and output register
// depends on sac_pkg and sac_ram
module sac_datapath #(
  parameter int unsigned MaxSlots     = sac_pkg::MaxSlots,
  parameter int unsigned MaxNeighbors = sac_pkg::MaxNeighbors,
  parameter int unsigned CountBits    = sac_pkg::CountBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sac_pkg::cmd_t             cmd_i,
  output sac_pkg::sts_t             sts_o,
  input  logic [sac_pkg::SymW-1:0]  symbol_i,
  input  logic [sac_pkg::SymW-1:0]  neighbor_i,
  input  logic [sac_pkg::DirW-1:0]  direction_i,
  output logic [sac_pkg::StW-1:0]   status_o,
  output logic [sac_pkg::SlotOW-1:0] symbol_slot_o,
  output logic [sac_pkg::PosOW-1:0] neighbor_slot_o,
  output logic [sac_pkg::CntOW-1:0] pair_count_o
);

  localparam int unsigned SlotW  = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned SCntW  = $clog2(MaxSlots + 1);
  localparam int unsigned PosW   = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int unsigned LenW   = $clog2(MaxNeighbors + 1);
  localparam int unsigned ListAW = SlotW + 2;
  localparam int unsigned Lists  = 1 << ListAW;
  localparam int unsigned EntAW  = ListAW + PosW;
  localparam int unsigned Entries = 1 << EntAW;
  localparam int unsigned IdxW   = (SCntW > LenW) ? SCntW : LenW;
  localparam int unsigned CW     = sac_pkg::CharW;

  logic [CW-1:0]   sym_q, nb_q;
  logic [1:0]      dir_q;
  logic            pass_q;
  logic [IdxW-1:0] idx_q;
  logic [SCntW-1:0] used_q;
  logic [SlotW-1:0] slot_q;
  logic [LenW-1:0]  len_q;
  logic [ListAW:0]  clr_q;
  logic             clearing;

  // input filter
  logic pass_d;
  always_comb begin
    pass_d = (symbol_i >= sac_pkg::ChLo) && (symbol_i <= sac_pkg::ChHi) &&
             (neighbor_i >= sac_pkg::ChLo) && (neighbor_i <= sac_pkg::ChHi) &&
             (neighbor_i != sac_pkg::ChLf) && (neighbor_i != sac_pkg::ChCr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
      idx_q  <= '0;
      used_q <= '0;
      slot_q <= '0;
    end else begin
      if (cmd_i.load) pass_q <= pass_d;
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + 1'b1;
      if (cmd_i.slot_rd) slot_q <= idx_q[SlotW-1:0];
      if (cmd_i.take_slot) begin
        slot_q <= used_q[SlotW-1:0];
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q <= symbol_i[CW-1:0];
      nb_q  <= neighbor_i[CW-1:0];
      dir_q <= direction_i;
    end
  end

  // slot character memory
  logic [SlotW-1:0] saddr;
  logic [CW-1:0]    schar;
  logic             srd_q;
  assign saddr = cmd_i.slot_wr ? used_q[SlotW-1:0] : idx_q[SlotW-1:0];
  sac_ram #(.Width(CW), .Depth(1 << SlotW)) u_slots (
    .clk_i, .we_i(cmd_i.slot_wr), .addr_i(saddr), .wdata_i(sym_q), .rdata_o(schar)
  );

  // list lengths, zeroed by a clearing pass after reset
  logic [ListAW-1:0] laddr, lens_addr;
  logic [LenW-1:0]   lraw, lwdata, lens_wdata;
  logic              lens_we;
  assign clearing   = ~clr_q[ListAW];
  assign laddr      = {slot_q, dir_q};
  assign lwdata     = (cmd_i.out_status == sac_pkg::StNewSymbol) ? LenW'(1) : len_q + 1'b1;
  assign lens_addr  = clearing ? clr_q[ListAW-1:0] : laddr;
  assign lens_we    = clearing || cmd_i.len_wr;
  assign lens_wdata = clearing ? '0 : lwdata;
  sac_ram #(.Width(LenW), .Depth(Lists)) u_lens (
    .clk_i, .we_i(lens_we), .addr_i(lens_addr), .wdata_i(lens_wdata), .rdata_o(lraw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      srd_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      srd_q <= cmd_i.slot_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_rd) len_q <= lraw;
  end

  // neighbor character and count memories
  logic [EntAW-1:0]     eaddr;
  logic [PosW-1:0]      epos;
  logic [CW-1:0]        echar;
  logic [CountBits-1:0] ecnt, cnt_q, cwdata;
  assign epos  = !cmd_i.list_wr ? idx_q[PosW-1:0] :
                 (cmd_i.out_status == sac_pkg::StIncr) ? idx_q[PosW-1:0] :
                 (cmd_i.out_status == sac_pkg::StNewSymbol) ? '0 : len_q[PosW-1:0];
  assign eaddr = {laddr, epos};
  sac_ram #(.Width(CW), .Depth(Entries)) u_chars (
    .clk_i, .we_i(cmd_i.list_wr && cmd_i.out_status != sac_pkg::StIncr),
    .addr_i(eaddr), .wdata_i(nb_q), .rdata_o(echar)
  );
  assign cwdata = (cmd_i.out_status == sac_pkg::StIncr) ? cnt_q : CountBits'(1);
  sac_ram #(.Width(CountBits), .Depth(Entries)) u_cnts (
    .clk_i, .we_i(cmd_i.list_wr), .addr_i(eaddr), .wdata_i(cwdata), .rdata_o(ecnt)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) cnt_q <= (&ecnt) ? ecnt : ecnt + 1'b1;
  end

  // status to controller
  always_comb begin
    sts_o.clearing   = clearing;
    sts_o.pass       = pass_q;
    sts_o.slot_done  = (idx_q >= IdxW'(used_q));
    sts_o.slot_hit   = srd_q && (schar == sym_q);
    sts_o.slots_full = (used_q >= SCntW'(MaxSlots));
    sts_o.list_done  = (idx_q >= IdxW'(len_q));
    sts_o.list_hit   = (echar == nb_q);
    sts_o.list_full  = (len_q >= LenW'(MaxNeighbors));
  end

  // output register
  logic [sac_pkg::CntOW-1:0] ocnt;
  assign ocnt = (cmd_i.out_status == sac_pkg::StIncr) ?
                sac_pkg::CntOW'(cnt_q) : sac_pkg::CntOW'(1);
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= cmd_i.out_status;
      if (cmd_i.out_zero) begin
        symbol_slot_o   <= '0;
        neighbor_slot_o <= '0;
        pair_count_o    <= '0;
      end else begin
        symbol_slot_o   <= sac_pkg::SlotOW'(slot_q);
        neighbor_slot_o <= (cmd_i.out_status == sac_pkg::StIncr) ?
                           sac_pkg::PosOW'(idx_q[PosW-1:0]) :
                           ((cmd_i.out_status == sac_pkg::StNewSymbol) ?
                            '0 : sac_pkg::PosOW'(len_q));
        pair_count_o    <= ocnt;
      end
    end
  end

endmodule

### rtl/sac_ctrl.sv
// sequencer for slot search, list search and update
// depends on sac_pkg
module sac_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sac_pkg::cmd_t cmd_o,
  input  sac_pkg::sts_t sts_i
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SCheck = 4'd1;
  localparam logic [3:0] SSRd   = 4'd2;
  localparam logic [3:0] SSCmp  = 4'd3;
  localparam logic [3:0] SLRd   = 4'd4;
  localparam logic [3:0] SLLen  = 4'd5;
  localparam logic [3:0] SLSt   = 4'd6;
  localparam logic [3:0] SERd   = 4'd7;
  localparam logic [3:0] SECmp  = 4'd8;
  localparam logic [3:0] SCnt   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SNewS  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       busy;

  assign busy        = state_q != SIdle;
  assign in_stall_o  = busy || sts_i.clearing || (ovalid_q && out_stall_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    cmd_o.out_status = sac_pkg::StIncr;
    case (state_q)
      SIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = SCheck;
        end
      end
      SCheck: begin
        if (!sts_i.pass) begin
          cmd_o.out_status = sac_pkg::StFiltered;
          cmd_o.out_zero   = 1'b1;
          state_d          = SOut;
        end else begin
          state_d = SSRd;
        end
      end
      SSRd: begin
        if (sts_i.slot_done) begin
          if (sts_i.slots_full) begin
            cmd_o.out_status = sac_pkg::StFull;
            cmd_o.out_zero   = 1'b1;
            state_d          = SOut;
          end else begin
            state_d = SNewS;
          end
        end else begin
          cmd_o.slot_rd = 1'b1;
          state_d       = SSCmp;
        end
      end
      SSCmp: begin
        if (sts_i.slot_hit) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = SLRd;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = SSRd;
        end
      end
      SNewS: begin
        cmd_o.slot_wr   = 1'b1;
        cmd_o.take_slot = 1'b1;
        state_d         = SLSt;
      end
      SLSt: begin
        cmd_o.len_wr     = 1'b1;
        cmd_o.list_wr    = 1'b1;
        cmd_o.len_rd     = 1'b1;
        cmd_o.out_status = sac_pkg::StNewSymbol;
        state_d          = SOut;
      end
      SLRd: state_d = SLLen;
      SLLen: begin
        cmd_o.len_rd = 1'b1;
        state_d      = SERd;
      end
      SERd: begin
        if (sts_i.list_done) begin
          if (sts_i.list_full) begin
            cmd_o.out_status = sac_pkg::StFull;
            cmd_o.out_zero   = 1'b1;
          end else begin
            cmd_o.out_status = sac_pkg::StNewNeighbor;
            cmd_o.list_wr    = 1'b1;
            cmd_o.len_wr     = 1'b1;
          end
          state_d = SOut;
        end else begin
          state_d = SECmp;
        end
      end
      SECmp: begin
        if (sts_i.list_hit) begin
          cmd_o.cnt_rd = 1'b1;
          state_d      = SCnt;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = SERd;
        end
      end
      SCnt: begin
        cmd_o.list_wr    = 1'b1;
        cmd_o.out_status = sac_pkg::StIncr;
        state_d          = SOut;
      end
      SOut: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (cmd_o.out_status != sac_pkg::StIncr || state_q == SCnt) begin
      if (state_q != SIdle && state_q != SOut && state_d == SOut) begin
        cmd_o.out_load = 1'b1;
        ovalid_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef SYNTHESIS
  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_d == SOut)) else $error("out load outside finish");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o) else $error("accept while busy");
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !ovalid_q) else $error("result pending at accept");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.clearing |-> in_stall_o) else $error("accept while clearing");
`endif

endmodule
